@@ design/text_console_cursor_scroll_top_defines.svh @@
// Assertion macros shared by the text console modules.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define TCCS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen out of reset.
`define TCCS_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

// Consequence that must hold in the cycle after its antecedent.
`define TCCS_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tccs_pkg.sv @@
// Shared types and constants of the text console.
package tccs_pkg;

  localparam int CMD_ADDR_W = 13;
  localparam int POS_W      = 11;
  localparam int CELL_W     = 16;
  localparam int IDX_W      = 11;
  localparam int COLOUR_W   = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FORE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK = 2'd1;

  localparam logic [7:0] CH_BS         = 8'h08;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_LAST_PRINT = 8'h7F;

  localparam logic [CELL_W-1:0] SCROLL_BLANK = 16'h0F20;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ,
    OP_CLEAR
  } op_e;

  // One classified request, ready for the memory side.
  typedef struct packed {
    op_e                   op;
    logic                  scroll;
    logic [CMD_ADDR_W-1:0] addr;
    logic [CELL_W-1:0]     data;
    logic [POS_W-1:0]      pos;
  } cmd_t;

endpackage

@@ design/tccs_if.sv @@
// Channel interfaces of the text console: request, response and register write.
interface tccs_req_if import tccs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [7:0]       char_code;
  logic [IDX_W-1:0] cell_index;

  modport source (output valid, req_type, char_code, cell_index, input ready);
  modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tccs_rsp_if import tccs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic [CELL_W-1:0] cell_data;

  modport source (output valid, cursor_position, cell_data, input ready);
  modport sink   (input valid, cursor_position, cell_data, output ready);
endinterface

interface tccs_cfg_if import tccs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COLOUR_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/tccs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/tccs_front.sv @@
// Front end: takes requests and register writes, tracks the cursor, emits commands.
module tccs_front import tccs_pkg::*; #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic [7:0]           char_code_i,
  input  logic [IDX_W-1:0]     cell_index_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COLOUR_W-1:0]  cfg_data_i,
  input  logic                 init_done_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output cmd_t                 push_cmd_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int RN_W  = ROW_W + 1;
  localparam int PH_W  = $clog2(TAB_WIDTH);
  localparam int NXT_W = $clog2(COLUMNS + TAB_WIDTH + 1);

  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [PH_W-1:0]     phase_q, phase_d, ph_nxt;
  logic [COLOUR_W-1:0] fore_q, back_q;
  logic [NXT_W-1:0]    col_nxt;
  logic [RN_W-1:0]     row_nxt;
  logic                row_inc, is_print, scroll, accept;
  logic [7:0]          attr;
  cmd_t                cmd;

  assign req_ready_o = init_done_i && !q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = req_valid_i && req_ready_o;
  assign attr        = {back_q, fore_q};

  // Cursor move of a put; phase tracks the column modulo the tab width.
  always_comb begin
    col_nxt  = NXT_W'(col_q);
    ph_nxt   = phase_q;
    row_inc  = 1'b0;
    is_print = 1'b0;
    case (char_code_i)
      CH_BS: begin
        if (col_q != '0) begin
          col_nxt = NXT_W'(col_q) - NXT_W'(1);
          ph_nxt  = (phase_q == '0) ? PH_W'(TAB_WIDTH - 1) : phase_q - PH_W'(1);
        end
      end
      CH_TAB: begin
        col_nxt = NXT_W'(col_q) + NXT_W'(TAB_WIDTH) - NXT_W'(phase_q);
        ph_nxt  = '0;
      end
      CH_CR: begin
        col_nxt = '0;
        ph_nxt  = '0;
      end
      CH_LF: begin
        col_nxt = '0;
        ph_nxt  = '0;
        row_inc = 1'b1;
      end
      default: begin
        if (char_code_i >= CH_SPACE && char_code_i <= CH_LAST_PRINT) begin
          is_print = 1'b1;
          col_nxt  = NXT_W'(col_q) + NXT_W'(1);
          ph_nxt   = (phase_q == PH_W'(TAB_WIDTH - 1)) ? '0 : phase_q + PH_W'(1);
        end
      end
    endcase
    // wrap past the right edge
    if (col_nxt >= NXT_W'(COLUMNS)) begin
      col_nxt = '0;
      ph_nxt  = '0;
      row_inc = 1'b1;
    end
    row_nxt = RN_W'(row_q) + RN_W'(row_inc);
    scroll  = row_nxt >= RN_W'(ROWS);
    if (scroll) begin
      row_nxt = RN_W'(ROWS - 1);
    end
  end

  always_comb begin
    cmd     = '0;
    cmd.op  = OP_NONE;
    col_d   = col_q;
    row_d   = row_q;
    phase_d = phase_q;
    unique case (req_type_i)
      REQ_PUT: begin
        cmd.op     = is_print ? OP_WRITE : OP_NONE;
        cmd.scroll = scroll;
        cmd.addr   = CMD_ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q));
        cmd.data   = {attr, char_code_i};
        col_d      = COL_W'(col_nxt);
        row_d      = ROW_W'(row_nxt);
        phase_d    = ph_nxt;
      end
      REQ_CLEAR: begin
        cmd.op   = OP_CLEAR;
        cmd.data = {attr, CH_SPACE};
        col_d    = '0;
        row_d    = '0;
        phase_d  = '0;
      end
      REQ_READ: begin
        // out-of-range reads answer zero without touching the store
        if (32'(cell_index_i) < CELLS) begin
          cmd.op   = OP_READ;
          cmd.addr = CMD_ADDR_W'(cell_index_i);
        end
      end
      default: begin
      end
    endcase
    cmd.pos = POS_W'(32'(row_d) * COLUMNS + 32'(col_d));
  end

  assign push_o     = accept;
  assign push_cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= '0;
      fore_q  <= COLOUR_W'(15);
      back_q  <= '0;
    end else begin
      if (accept) begin
        col_q   <= col_d;
        row_q   <= row_d;
        phase_q <= phase_d;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_FORE: fore_q <= cfg_data_i;
          CFG_BACK: back_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ design/tccs_queue.sv @@
// Short command queue between the front end and the memory side.
`include "text_console_cursor_scroll_top_defines.svh"

module tccs_queue import tccs_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_cmd_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q;

  assign full_o    = count_q == CNT_W'(DEPTH);
  assign valid_o   = count_q != '0;
  assign pop_cmd_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  `TCCS_NEVER(a_push_full, push_i && full_o, "command pushed into a full queue")
  `TCCS_NEVER(a_pop_empty, pop_i && !valid_o, "command popped from an empty queue")
  `TCCS_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count past its depth")

endmodule

@@ design/tccs_back.sv @@
// Back end: executes commands on the cell store and holds the response register.
`include "text_console_cursor_scroll_top_defines.svh"

module tccs_back import tccs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  output logic              init_done_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output logic [POS_W-1:0]  rsp_pos_o,
  output logic [CELL_W-1:0] rsp_data_o
);

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int AW        = $clog2(CELLS);
  localparam int SHIFT_END = CELLS - COLUMNS;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FILL  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_COPY  = 3'd4;
  localparam logic [2:0] ST_BLANK = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [CELL_W-1:0] fill_q, fill_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic [POS_W-1:0]  rsp_pos_q;
  logic [CELL_W-1:0] rsp_data_q, ld_data;
  logic              slot_free, pop, load;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign slot_free = !rsp_valid_q || rsp_ready_i;
  assign pop       = (state_q == ST_IDLE) && cmd_valid_i && slot_free;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    pos_d       = pos_q;
    we          = 1'b0;
    waddr       = cnt_q;
    wdata       = fill_q;
    re          = 1'b0;
    raddr       = cmd_i.addr[AW-1:0];
    load        = 1'b0;
    ld_data     = '0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    unique case (state_q)
      ST_INIT: begin
        // zero the store after reset
        we    = 1'b1;
        wdata = '0;
        if (cnt_q == AW'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (pop) begin
          pos_d = cmd_i.pos;
          cnt_d = '0;
          unique case (cmd_i.op)
            OP_WRITE: begin
              we    = 1'b1;
              waddr = cmd_i.addr[AW-1:0];
              wdata = cmd_i.data;
              if (cmd_i.scroll) begin
                state_d = ST_COPY;
              end else begin
                load = 1'b1;
              end
            end
            OP_NONE: begin
              if (cmd_i.scroll) begin
                state_d = ST_COPY;
              end else begin
                load = 1'b1;
              end
            end
            OP_READ: begin
              re      = 1'b1;
              state_d = ST_READ;
            end
            OP_CLEAR: begin
              fill_d  = cmd_i.data;
              state_d = ST_FILL;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (cnt_q == AW'(CELLS - 1)) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_READ: begin
        load    = 1'b1;
        ld_data = rdata;
        state_d = ST_IDLE;
      end
      ST_COPY: begin
        // read one row down, write the data back in the cycle after
        if (cnt_q != '0) begin
          we    = 1'b1;
          waddr = cnt_q - AW'(1);
          wdata = rdata;
        end
        if (cnt_q == AW'(SHIFT_END)) begin
          state_d = ST_BLANK;
        end else begin
          re    = 1'b1;
          raddr = cnt_q + AW'(COLUMNS);
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_BLANK: begin
        we    = 1'b1;
        wdata = SCROLL_BLANK;
        if (cnt_q == AW'(CELLS - 1)) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (load) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    pos_q  <= pos_d;
    if (load) begin
      rsp_pos_q  <= pos_d;
      rsp_data_q <= ld_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign pop_o       = pop;
  assign init_done_o = state_q != ST_INIT;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_pos_o   = rsp_pos_q;
  assign rsp_data_o  = rsp_data_q;

  `TCCS_NEVER(a_no_overwrite, rsp_valid_q && !rsp_ready_i && load, "pending response overwritten")
  `TCCS_NEXT(a_read_rsp, state_q == ST_READ, rsp_valid_q, "read finished without a response")
  `TCCS_NEXT(a_init_once, state_q != ST_INIT, state_q != ST_INIT, "store sweep restarted")
  `TCCS_ASSERT(a_wr_range, !we || (32'(waddr) < CELLS), "store write past the last cell")

endmodule

@@ design/text_console_cursor_scroll_top.sv @@
// Top level of the text console with cursor and scroll.
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   req_type, char_code, cell_index
//   rsp_o    out  valid/ready   cursor_position, cell_data
//   cfg_i    in   valid/ready   index, data (0 fore colour, 1 back colour)
//
// Put without scroll and ignored requests answer from the idle state; a read waits for
// the registered read port of the cell store. A clear rewrites every cell, and a scroll
// copies each row up by one and fills the last row with blanks.
// After reset the store is zeroed, all ROWS*COLUMNS cells (2000 by default); req_i is not
// ready until then. A two-entry command queue lets requests enter while a result waits.
module text_console_cursor_scroll_top import tccs_pkg::*; #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tccs_req_if.sink    req_i,
  tccs_rsp_if.source  rsp_o,
  tccs_cfg_if.sink    cfg_i
);

  cmd_t push_cmd, pop_cmd;
  logic push, pop, q_full, q_valid, init_done;

  tccs_front #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .req_type_i   (req_i.req_type),
    .char_code_i  (req_i.char_code),
    .cell_index_i (req_i.cell_index),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_ready_o  (cfg_i.ready),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .init_done_i  (init_done),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  tccs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  tccs_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .init_done_o (init_done),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_pos_o   (rsp_o.cursor_position),
    .rsp_data_o  (rsp_o.cell_data)
  );

endmodule
